// ===== hdl/mdmad_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion detector shared definitions
// Sequencer states, configuration register codes and field widths.
// ----------------------------------------------------------------------------
package mdmad_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MARGIN_W   = 12;
	localparam int HOLD_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd1;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd60;
	localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd200;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_WALK,
		ST_ADIV,
		ST_ACT,
		ST_NOISE,
		ST_OUT
	} state_t;

endpackage

// ===== hdl/motion_detector_mad_threshold.sv =====
// ----------------------------------------------------------------------------
// Motion detector with mean absolute deviation threshold
// Windowed activity measure against an adaptive noise floor driving a lamp.
// ----------------------------------------------------------------------------
// Each request on s_axis carries one converter sample in tdata. It enters a
// chain of WINDOW cells, the running window sum is updated and divided by the
// window length to give the mean. A partial sum then walks down the chain,
// each cell adding its absolute deviation from the mean, and the total is
// divided again to give the activity value. The noise floor, threshold, hold
// counter and lamp are updated and one result request leaves on m_axis.
// Each item runs through the walk over the cell chain and two passes through
// the four-stage divider. The block takes no new sample before it is through
// with the last one, and s_axis_tready is high only between items.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next item and waits with it until the register is free.
// Reset clears the window, sum, noise floor, hold counter and lamp and loads
// the margin and hold registers with their defaults. Configuration writes on
// cfg_we are taken at any time and should be made while the block is idle.
// ----------------------------------------------------------------------------
module motion_detector_mad_threshold #(
	parameter int WINDOW      = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0: sample.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,

	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0: activity, noise_level, threshold, light_on.
	output logic [((2*SAMPLE_BITS + ((SAMPLE_BITS > mdmad_pkg::MARGIN_W) ?
		SAMPLE_BITS : mdmad_pkg::MARGIN_W) + 2 + 7)/8)*8-1:0] m_axis_tdata,

	input  logic                                 cfg_we,
	input  logic [mdmad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mdmad_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int THR_W  = ((SAMPLE_BITS > mdmad_pkg::MARGIN_W) ?
		SAMPLE_BITS : mdmad_pkg::MARGIN_W) + 1;
	localparam int CNT_W  = $clog2(WINDOW);
	localparam int OUT_W  = 2*SAMPLE_BITS + THR_W + 1;
	localparam int TDO_W  = ((OUT_W + 7)/8)*8;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

	mdmad_pkg::state_t state_q, state_d;

	logic [mdmad_pkg::MARGIN_W-1:0] margin_q;
	logic [mdmad_pkg::HOLD_W-1:0]   hold_ticks_q;
	logic [mdmad_pkg::HOLD_W-1:0]   hold_q;
	logic                           lamp_q;
	logic [SUM_W-1:0]               sum_q;
	logic [SAMPLE_BITS-1:0]         mean_q;
	logic [SAMPLE_BITS-1:0]         act_q;
	logic [SAMPLE_BITS-1:0]         noise_q;
	logic [THR_W-1:0]               thr_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           out_valid_q;
	logic [OUT_W-1:0]               out_q;

	logic [SAMPLE_BITS-1:0] sample;
	logic [SAMPLE_BITS-1:0] cell_din  [WINDOW];
	logic [SAMPLE_BITS-1:0] cell_dout [WINDOW];
	logic [SUM_W-1:0]       cell_pin  [WINDOW];
	logic [SUM_W-1:0]       cell_pout [WINDOW];
	logic [SUM_W-1:0]       sum_next;
	logic                   accept;
	logic                   out_load;
	logic                   div_start;
	logic [SUM_W-1:0]       div_x;
	logic                   div_done;
	logic [SUM_W-1:0]       div_q;

	logic [SAMPLE_BITS+4:0]         noise_acc;
	logic [SAMPLE_BITS-1:0]         noise_next;
	logic                           detect;
	logic [mdmad_pkg::HOLD_W-1:0]   hold_ld;
	logic [mdmad_pkg::HOLD_W-1:0]   hold_next;
	logic                           lamp_next;

	assign sample   = s_axis_tdata[SAMPLE_BITS-1:0];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign sum_next = sum_q - SUM_W'(cell_dout[WINDOW-1]) + SUM_W'(sample);

	// Cell chain: new samples enter at the head and the oldest drops off the tail.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_din[i] = sample;
			assign cell_pin[i] = '0;
		end else begin : g_body
			assign cell_din[i] = cell_dout[i-1];
			assign cell_pin[i] = cell_pout[i-1];
		end

		mdmad_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.SUM_W       (SUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.din      (cell_din[i]),
			.mean     (mean_q),
			.psum_in  (cell_pin[i]),
			.dout     (cell_dout[i]),
			.psum_out (cell_pout[i])
		);
	end

	mdmad_divw #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_divw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.x      (div_x),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdmad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		div_x         = sum_next;
		out_load      = 1'b0;
		case (state_q)
			mdmad_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					div_start = 1'b1;
					state_d   = mdmad_pkg::ST_MEAN;
				end
			end
			mdmad_pkg::ST_MEAN: begin
				if (div_done) begin
					state_d = mdmad_pkg::ST_WALK;
				end
			end
			mdmad_pkg::ST_WALK: begin
				if (cnt_q == CNT_LAST) begin
					state_d = mdmad_pkg::ST_ADIV;
				end
			end
			mdmad_pkg::ST_ADIV: begin
				div_start = 1'b1;
				div_x     = cell_pout[WINDOW-1];
				state_d   = mdmad_pkg::ST_ACT;
			end
			mdmad_pkg::ST_ACT: begin
				if (div_done) begin
					state_d = mdmad_pkg::ST_NOISE;
				end
			end
			mdmad_pkg::ST_NOISE: begin
				state_d = mdmad_pkg::ST_OUT;
			end
			mdmad_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = mdmad_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdmad_pkg::ST_IDLE;
			end
		endcase
	end

	// Noise floor follows (15 * floor + activity) / 16 while no hold is running.
	assign noise_acc  = ({1'b0, noise_q, 4'b0000} - (SAMPLE_BITS+5)'(noise_q))
		+ (SAMPLE_BITS+5)'(act_q);
	assign noise_next = (hold_q == '0) ? noise_acc[SAMPLE_BITS+3:4] : noise_q;

	assign detect    = THR_W'(act_q) > thr_q;
	assign hold_ld   = detect ? hold_ticks_q : hold_q;
	assign hold_next = (hold_ld != '0) ?
		(hold_ld - {{(mdmad_pkg::HOLD_W-1){1'b0}}, 1'b1}) : hold_ld;
	always_comb begin
		lamp_next = detect ? 1'b1 : lamp_q;
		if (hold_ld != '0 && hold_next == '0 && THR_W'(act_q) < thr_q) begin
			lamp_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q     <= mdmad_pkg::MARGIN_RESET;
			hold_ticks_q <= mdmad_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mdmad_pkg::REG_MARGIN: margin_q     <= cfg_data[mdmad_pkg::MARGIN_W-1:0];
				mdmad_pkg::REG_HOLD:   hold_ticks_q <= cfg_data[mdmad_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			noise_q     <= '0;
			hold_q      <= '0;
			lamp_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				sum_q <= sum_next;
			end
			if (state_q == mdmad_pkg::ST_WALK) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : (cnt_q + CNT_W'(1));
			end
			if (state_q == mdmad_pkg::ST_NOISE) begin
				noise_q <= noise_next;
			end
			if (out_load) begin
				hold_q      <= hold_next;
				lamp_q      <= lamp_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mdmad_pkg::ST_MEAN && div_done) begin
			mean_q <= div_q[SAMPLE_BITS-1:0];
		end
		if (state_q == mdmad_pkg::ST_ACT && div_done) begin
			act_q <= div_q[SAMPLE_BITS-1:0];
		end
		if (state_q == mdmad_pkg::ST_NOISE) begin
			thr_q <= THR_W'(noise_next) + THR_W'(margin_q);
		end
		if (out_load) begin
			out_q <= {lamp_next, thr_q, noise_q, act_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDO_W'(out_q);

	a_lamp_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!lamp_q |-> hold_q == '0)
		else $error("hold counter running while the lamp is off");

	a_div_state : assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == mdmad_pkg::ST_MEAN || state_q == mdmad_pkg::ST_ACT))
		else $error("divider result arrived outside a waiting state");

	a_out_rise : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == mdmad_pkg::ST_OUT))
		else $error("result presented without passing the output state");

	a_walk_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		state_q != mdmad_pkg::ST_WALK |-> cnt_q == '0)
		else $error("walk counter not cleared outside the walk");

endmodule

// ===== hdl/mdmad_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one sample of the window and adds its absolute deviation from the
// mean to the partial sum that travels down the chain.
// ----------------------------------------------------------------------------
module mdmad_cell #(
	parameter int SAMPLE_BITS = 12,
	parameter int SUM_W       = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift_en,
	input  logic [SAMPLE_BITS-1:0] din,
	input  logic [SAMPLE_BITS-1:0] mean,
	input  logic [SUM_W-1:0]       psum_in,
	output logic [SAMPLE_BITS-1:0] dout,
	output logic [SUM_W-1:0]       psum_out
);

	logic [SAMPLE_BITS-1:0] value_q;
	logic [SUM_W-1:0]       psum_q;
	logic [SAMPLE_BITS-1:0] dev;

	assign dev = (value_q >= mean) ? (value_q - mean) : (mean - value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift_en) begin
			value_q <= din;
		end
	end

	always_ff @(posedge clk) begin
		psum_q <= psum_in + SUM_W'(dev);
	end

	assign dout     = value_q;
	assign psum_out = psum_q;

endmodule

// ===== hdl/mdmad_divw.sv =====
// ----------------------------------------------------------------------------
// Divide by window length
// Four-stage pipelined floor division by the constant window length, using a
// reciprocal multiplication followed by a single correction step.
// ----------------------------------------------------------------------------
module mdmad_divw #(
	parameter int WINDOW = 16,
	parameter int SUM_W  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] x,
	output logic             done,
	output logic [SUM_W-1:0] q
);

	localparam logic [SUM_W-1:0]   RECIP   = SUM_W'((64'd1 << SUM_W) / WINDOW);
	localparam logic [SUM_W-1:0]   WIN_C   = SUM_W'(WINDOW);
	localparam logic [2*SUM_W-1:0] WIN_EXT = (2*SUM_W)'(WINDOW);

	logic [3:0]           vld_q;
	logic [SUM_W-1:0]     x_s1;
	logic [SUM_W-1:0]     x_s2;
	logic [SUM_W-1:0]     x_s3;
	logic [2*SUM_W-1:0]   prod_s2;
	logic [SUM_W-1:0]     q0_s3;
	logic [2*SUM_W-1:0]   qw_s3;
	logic [SUM_W-1:0]     q_s4;
	logic [SUM_W-1:0]     q0;
	logic [2*SUM_W-1:0]   qw_full;
	logic [SUM_W-1:0]     rem;

	assign q0      = prod_s2[2*SUM_W-1:SUM_W];
	assign qw_full = (2*SUM_W)'(q0) * WIN_EXT;
	assign rem     = x_s3 - qw_s3[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		x_s2    <= x_s1;
		prod_s2 <= (2*SUM_W)'(x_s1) * (2*SUM_W)'(RECIP);
		x_s3    <= x_s2;
		q0_s3   <= q0;
		qw_s3   <= qw_full;
		q_s4    <= (rem >= WIN_C) ? (q0_s3 + SUM_W'(1)) : q0_s3;
	end

	assign done = vld_q[3];
	assign q    = q_s4;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Motion detector testbench
// Drives converter samples into the mean absolute deviation motion detector
// and checks every activity, noise floor, threshold and lamp result against a
// cycle-free model of the window, noise filter and hold counter. A directed
// table comes first, then phases of random sample patterns under changing
// margin and hold settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

	localparam int SAMPLE_W = 12;
	localparam int DEPTH    = 16;
	localparam int IN_W     = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_W    = ((2 * SAMPLE_W + mdmad_pkg::MARGIN_W + 2 + 7) / 8) * 8;
	localparam int PHASES   = 8;
	localparam int PHASE_ITEMS = 104;

	localparam logic [mdmad_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [mdmad_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	typedef struct packed {
		logic [11:0] activity;
		logic [11:0] noise;
		logic [12:0] thr;
		logic        light;
	} result_t;

	typedef struct packed {
		logic                             is_cfg;
		logic [mdmad_pkg::CFG_IDX_W-1:0]  idx;
		logic [mdmad_pkg::CFG_DATA_W-1:0] data;
		logic [11:0]                      sample;
		logic                             known;
		result_t                          want;
	} step_t;

	typedef enum {QUIET, BURST, SWING, STEADY} sample_mode_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [mdmad_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mdmad_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [11:0] win [DEPTH];
	logic [3:0] slot;
	int unsigned win_sum;
	int unsigned noise_floor;
	int unsigned hold_cnt;
	logic lamp;
	int unsigned margin_set;
	int unsigned hold_set;

	result_t expected_q [$];
	step_t plan [$];
	int err_count;
	bit calm;

	motion_detector_mad_threshold uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic result_t track_motion(input logic [11:0] s);
		int unsigned mean;
		int unsigned dev;
		int unsigned act;
		int unsigned thr;
		result_t r;
		win_sum = win_sum - 32'(win[slot]) + 32'(s);
		win[slot] = s;
		slot = slot + 4'd1;
		mean = win_sum / DEPTH;
		dev = 0;
		for (int i = 0; i < DEPTH; i++)
			dev += (32'(win[i]) >= mean) ? (32'(win[i]) - mean) : (mean - 32'(win[i]));
		act = dev / DEPTH;
		if (hold_cnt == 0)
			noise_floor = (noise_floor * 15 + act) / 16;
		thr = noise_floor + margin_set;
		if (act > thr) begin
			lamp = 1'b1;
			hold_cnt = hold_set;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0 && act < thr)
				lamp = 1'b0;
		end
		r.activity = act[11:0];
		r.noise = noise_floor[11:0];
		r.thr = thr[12:0];
		r.light = lamp;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic step_t sample_row(input logic [11:0] s);
		step_t t;
		t = '0;
		t.sample = s;
		return t;
	endfunction

	function automatic step_t known_row(input logic [11:0] s, input int act,
			input int noise, input int thr, input bit light);
		step_t t;
		t = sample_row(s);
		t.known = 1'b1;
		t.want = '{activity: act[11:0], noise: noise[11:0], thr: thr[12:0], light: light};
		return t;
	endfunction

	function automatic step_t config_row(input logic [mdmad_pkg::CFG_IDX_W-1:0] idx,
			input logic [mdmad_pkg::CFG_DATA_W-1:0] value);
		step_t t;
		t = '0;
		t.is_cfg = 1'b1;
		t.idx = idx;
		t.data = value;
		return t;
	endfunction

	task automatic send_sample(input logic [11:0] s, input bit known, input result_t want);
		result_t got;
		int gap;
		s_axis_tdata <= {{(IN_W - SAMPLE_W){1'b0}}, s};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		got = track_motion(s);
		expected_q.push_back(known ? want : got);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [mdmad_pkg::CFG_IDX_W-1:0] idx,
			input logic [mdmad_pkg::CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == mdmad_pkg::REG_MARGIN)
			margin_set = 32'(value[mdmad_pkg::MARGIN_W-1:0]);
		else if (idx == mdmad_pkg::REG_HOLD)
			hold_set = 32'(value);
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			err_count++;
			if (err_count <= 50)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				err_count++;
				if (err_count <= 50)
					$display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				check_field("activity", 32'(want.activity), 32'(m_axis_tdata[11:0]));
				check_field("noise_level", 32'(want.noise), 32'(m_axis_tdata[23:12]));
				check_field("threshold", 32'(want.thr), 32'(m_axis_tdata[36:24]));
				check_field("light_on", 32'(want.light), 32'(m_axis_tdata[37]));
			end
		end
	end

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		sample_mode_t mode;
		int left;
		int run;
		int base;
		int amp;
		int v;
		logic [11:0] lo;
		logic [11:0] hi;
		logic [11:0] s;
		logic [11:0] m;
		logic [15:0] h;
		bit toggle;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = mdmad_pkg::REG_MARGIN;
		cfg_data = '0;
		err_count = 0;
		calm = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			win[i] = '0;
		slot = '0;
		win_sum = 0;
		noise_floor = 0;
		hold_cnt = 0;
		lamp = 1'b0;
		margin_set = 32'(mdmad_pkg::MARGIN_RESET);
		hold_set = 32'(mdmad_pkg::HOLD_RESET);

		plan = '{
			known_row(12'd0, 0, 0, 60, 1'b0),
			known_row(12'd4095, 479, 29, 89, 1'b1),
			sample_row(12'd4095), sample_row(12'd0), sample_row(12'hAAA),
			sample_row(12'h555), sample_row(12'd4095), sample_row(12'd0),
			config_row(mdmad_pkg::REG_MARGIN, 16'hFFFF),
			sample_row(12'd0), sample_row(12'd4095), sample_row(12'd0),
			config_row(mdmad_pkg::REG_MARGIN, 16'hF000),
			config_row(mdmad_pkg::REG_HOLD, 16'h0000),
			sample_row(12'd0), sample_row(12'd4095), sample_row(12'd0),
			sample_row(12'd4095), sample_row(12'd0),
			config_row(REG_UNUSED_A, 16'h0001),
			config_row(REG_UNUSED_B, 16'h0002),
			sample_row(12'd4095), sample_row(12'd0),
			config_row(mdmad_pkg::REG_HOLD, 16'h0001),
			sample_row(12'd2048), sample_row(12'd2048), sample_row(12'd2048),
			sample_row(12'd2047)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_sample(plan[i].sample, plan[i].known, plan[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			calm = (p % 3 == 2);
			case ($urandom_range(0, 4))
				0: m = 12'd0;
				1: m = 12'd4095;
				2: m = 12'($urandom_range(0, 15));
				3: m = 12'($urandom_range(16, 300));
				default: m = 12'($urandom_range(0, 4095));
			endcase
			if (p == PHASES - 1)
				m = 12'($urandom_range(0, 15));
			write_reg(mdmad_pkg::REG_MARGIN, {4'($urandom_range(0, 15)), m});
			case ($urandom_range(0, 9))
				0: h = 16'd0;
				1, 2: h = 16'd1;
				3, 4, 5: h = 16'($urandom_range(2, 8));
				default: h = 16'($urandom_range(9, 300));
			endcase
			if (p == PHASES - 1)
				h = 16'hFFFF;
			write_reg(mdmad_pkg::REG_HOLD, h);
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
					16'($urandom_range(0, 65535)));

			left = PHASE_ITEMS;
			while (left > 0) begin
				v = $urandom_range(0, 99);
				mode = (v < 45) ? QUIET : (v < 65) ? BURST : (v < 85) ? SWING : STEADY;
				run = $urandom_range(4, 30);
				if (run > left)
					run = left;
				base = $urandom_range(0, 4095);
				amp = $urandom_range(0, 6);
				lo = 12'($urandom_range(0, 4095));
				hi = 12'($urandom_range(0, 4095));
				toggle = 1'b0;
				repeat (run) begin
					case (mode)
						QUIET: begin
							v = base + $urandom_range(0, 2 * amp) - amp;
							s = (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : v[11:0];
						end
						BURST: s = 12'($urandom_range(0, 4095));
						SWING: begin
							s = toggle ? hi : lo;
							toggle = !toggle;
						end
						default: s = base[11:0];
					endcase
					send_sample(s, 1'b0, '0);
					if ($urandom_range(0, 99) == 0)
						drain();
				end
				left -= run;
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
